// ===== src/swmm_pkg.sv =====
package swmm_pkg;

  localparam int VALUE_BITS  = 10;
  localparam int MAX_WINDOW  = 256;

  localparam int ACTION_W    = 2;
  localparam int VALUE_IN_W  = 10;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int NEED_W      = 9;
  localparam int MATCH_OUT_W = 9;
  localparam int HITS_W      = 32;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 1 + MATCH_OUT_W + 1 + HITS_W;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [NEED_W-1:0] NEED_MAX    = 9'd511;
  localparam logic [CFG_W-1:0]  CFG_LEN_RST = 9'd1;
  localparam logic [CFG_W-1:0]  CFG_THR_RST = 9'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_REQUIRE = 2'd1,
    ACT_PUSH    = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 1'b0,
    CFG_THRESHOLD  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic fetch;
    logic evict;
    logic commit;
    logic sweep_clr;
    logic sweep_step;
    logic sweep_need;
  } swmm_cmd_t;

  typedef struct packed {
    action_t act;
    logic    full;
    logic    sweep_last;
  } swmm_sts_t;

endpackage

// ===== src/sliding_window_multiset_match_core.sv =====
// Channel   Direction  Handshake             Payload
// in_       input      in_tvalid/in_tready   in_tdata: action, value
// out_      output     out_tvalid/out_tready out_tdata: window_full, matched,
//                                            window_ok, hits
// cfg_      input      cfg_we                cfg_index, cfg_wdata
//
// A push goes through load, fetch and finish steps, with an evict step before finish
// once the window is full, since the single read port of the count memories is used
// first for the new value and then for the evicted one. Other actions skip the evict
// step, and a clear then sweeps all 2**VALUE_BITS values. After reset a sweep zeroes
// both count memories while in_tready is low; a window_len write sweeps only the
// have counts. A result that is not taken holds the last step of the next item.
module sliding_window_multiset_match_core #(
  parameter int VALUE_BITS = swmm_pkg::VALUE_BITS,
  parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // action [1:0], value [11:2]
  input  logic [swmm_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // window_full [0], matched [9:1], window_ok [10], hits [42:11]
  output logic [swmm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [swmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swmm_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int FULL_BIT = 0;
  localparam int OK_BIT   = 1 + swmm_pkg::MATCH_OUT_W;

  swmm_pkg::swmm_cmd_t cmd;
  swmm_pkg::swmm_sts_t sts;
  logic                cfg_len_wr;
  logic                o_full, o_ok;
  logic [swmm_pkg::MATCH_OUT_W-1:0] o_matched;
  logic [swmm_pkg::HITS_W-1:0]      o_hits;

  assign cfg_len_wr = cfg_we && (cfg_index == swmm_pkg::CFG_WINDOW_LEN);

  assign out_tdata = {{swmm_pkg::OUT_PAD_W{1'b0}}, o_hits, o_ok, o_matched, o_full};

  swmm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_len_wr (cfg_len_wr),
    .sts        (sts),
    .cmd        (cmd)
  );

  swmm_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_action (in_tdata[swmm_pkg::ACTION_W-1:0]),
    .in_value  (in_tdata[swmm_pkg::ACTION_W +: swmm_pkg::VALUE_IN_W]),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .o_full    (o_full),
    .o_matched (o_matched),
    .o_ok      (o_ok),
    .o_hits    (o_hits)
  );

  a_ok_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[OK_BIT] || out_tdata[FULL_BIT]))
    else $error("window_ok set on a window that is not full");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second item taken while one is in progress");

  a_sweep_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("item taken before the count memories were cleared");

endmodule

// ===== src/swmm_ram.sv =====
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/swmm_ctrl.sv =====
module swmm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_len_wr,
  input  swmm_pkg::swmm_sts_t sts,
  output swmm_pkg::swmm_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FETCH,
    ST_EVICT,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   sweep_need_r, sweep_need_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    sweep_need_nxt = sweep_need_r;
    cmd            = '0;
    unique case (state_r)
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.sweep_need = sweep_need_r;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        if (sts.act == swmm_pkg::ACT_PUSH && sts.full) begin
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          if (sts.act == swmm_pkg::ACT_CLEAR) begin
            cmd.sweep_clr  = 1'b1;
            sweep_need_nxt = 1'b1;
            state_nxt      = ST_SWEEP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_len_wr) begin
      cmd.sweep_clr = 1'b1;
      if (state_r != ST_SWEEP) begin
        sweep_need_nxt = 1'b0;
      end
      state_nxt = ST_SWEEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      out_valid_r  <= 1'b0;
      sweep_need_r <= 1'b1;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      sweep_need_r <= sweep_need_nxt;
    end
  end

endmodule

// ===== src/swmm_dp.sv =====
module swmm_dp #(
  parameter int VALUE_BITS = swmm_pkg::VALUE_BITS,
  parameter int MAX_WINDOW = swmm_pkg::MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [swmm_pkg::ACTION_W-1:0]       in_action,
  input  logic [swmm_pkg::VALUE_IN_W-1:0]     in_value,
  input  logic                                cfg_we,
  input  logic [swmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swmm_pkg::CFG_W-1:0]          cfg_wdata,
  input  swmm_pkg::swmm_cmd_t                 cmd,
  output swmm_pkg::swmm_sts_t                 sts,
  output logic                                o_full,
  output logic [swmm_pkg::MATCH_OUT_W-1:0]    o_matched,
  output logic                                o_ok,
  output logic [swmm_pkg::HITS_W-1:0]         o_hits
);

  localparam int NVALUES = 1 << VALUE_BITS;
  localparam int WP_W    = $clog2(MAX_WINDOW);
  localparam int FL_W    = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W   = (FL_W > swmm_pkg::CFG_W) ? FL_W : swmm_pkg::CFG_W;
  localparam int HAVE_W  = FL_W;
  localparam int NEED_W  = swmm_pkg::NEED_W;
  localparam int HITS_W  = swmm_pkg::HITS_W;
  localparam int MO_W    = swmm_pkg::MATCH_OUT_W;
  localparam int CFG_W   = swmm_pkg::CFG_W;
  localparam logic [WP_W-1:0]  WP_LAST = WP_W'(MAX_WINDOW - 1);
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WINDOW);

  logic [CFG_W-1:0]      cfg_len_r, cfg_len_nxt, cfg_thr_r, cfg_thr_nxt;
  logic [WP_W-1:0]       wp_r, wp_nxt, wp_inc;
  logic [FL_W-1:0]       fl_r, fl_nxt, fl_push;
  logic [CMP_W-1:0]      match_r, match_nxt, match_add;
  logic [HITS_W-1:0]     hits_r, hits_nxt;
  logic [VALUE_BITS-1:0] sweep_cnt_r, sweep_cnt_nxt;

  swmm_pkg::action_t     act_r, act_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt, v_in;
  logic [HAVE_W-1:0]     hv_r, hv_nxt, hv_inc;
  logic [NEED_W-1:0]     nv_r, nv_nxt;
  logic                  o_full_nxt, o_ok_nxt;
  logic [MO_W-1:0]       o_matched_nxt;
  logic [HITS_W-1:0]     o_hits_nxt;

  logic [VALUE_BITS-1:0] cnt_raddr, have_waddr, need_waddr, store_rd;
  logic [HAVE_W-1:0]     have_rd, have_wd, have_dec;
  logic [NEED_W-1:0]     need_rd, need_wd;
  logic                  have_we, need_we, store_we;
  logic [WP_W-1:0]       store_raddr;

  logic [FL_W:0]         wp_ext, fl_ext, idx_sum;
  logic [CMP_W-1:0]      len_c, wl_ext;
  logic                  full, full_push, ok_push, add_hit, req_hit, need_sat;
  logic                  have_nz, evict_dec;

  assign v_in = VALUE_BITS'(in_value);

  assign wl_ext = CMP_W'(cfg_len_r);
  assign len_c  = (cfg_len_r == '0) ? CMP_W'(1) : ((wl_ext > MAX_CMP) ? MAX_CMP : wl_ext);
  assign full   = CMP_W'(fl_r) >= len_c;

  assign wp_ext      = (FL_W + 1)'(wp_r);
  assign fl_ext      = (FL_W + 1)'(fl_r);
  assign idx_sum     = (wp_ext >= fl_ext) ? (wp_ext - fl_ext)
                       : (wp_ext + (FL_W + 1)'(MAX_WINDOW) - fl_ext);
  assign store_raddr = idx_sum[WP_W-1:0];

  assign cnt_raddr = cmd.load ? v_in : store_rd;

  assign have_nz   = (have_rd != '0);
  assign have_dec  = have_nz ? (have_rd - HAVE_W'(1)) : have_rd;
  assign evict_dec = have_nz && (CMP_W'(have_rd) <= CMP_W'(need_rd)) && (match_r != '0);

  assign hv_inc    = hv_r + HAVE_W'(1);
  assign add_hit   = CMP_W'(hv_inc) <= CMP_W'(nv_r);
  assign match_add = match_r + CMP_W'(add_hit);
  assign fl_push   = full ? fl_r : (fl_r + FL_W'(1));
  assign full_push = CMP_W'(fl_push) >= len_c;
  assign ok_push   = full_push && (match_add >= CMP_W'(cfg_thr_r));
  assign wp_inc    = (wp_r == WP_LAST) ? '0 : (wp_r + WP_W'(1));
  assign need_sat  = (nv_r == swmm_pkg::NEED_MAX);
  assign req_hit   = !need_sat && (CMP_W'(hv_r) > CMP_W'(nv_r));

  assign sts.act        = act_r;
  assign sts.full       = full;
  assign sts.sweep_last = (sweep_cnt_r == '1);

  always_comb begin
    cfg_len_nxt   = cfg_len_r;
    cfg_thr_nxt   = cfg_thr_r;
    wp_nxt        = wp_r;
    fl_nxt        = fl_r;
    match_nxt     = match_r;
    hits_nxt      = hits_r;
    sweep_cnt_nxt = sweep_cnt_r;
    act_nxt       = act_r;
    v_nxt         = v_r;
    hv_nxt        = hv_r;
    nv_nxt        = nv_r;
    o_full_nxt    = o_full;
    o_ok_nxt      = o_ok;
    o_matched_nxt = o_matched;
    o_hits_nxt    = o_hits;
    have_we       = 1'b0;
    have_waddr    = v_r;
    have_wd       = hv_inc;
    need_we       = 1'b0;
    need_waddr    = v_r;
    need_wd       = nv_r + NEED_W'(1);
    store_we      = 1'b0;

    if (cmd.load) begin
      act_nxt = swmm_pkg::action_t'(in_action);
      v_nxt   = v_in;
    end

    if (cmd.fetch) begin
      hv_nxt = have_rd;
      nv_nxt = need_rd;
    end

    if (cmd.evict) begin
      have_we    = 1'b1;
      have_waddr = store_rd;
      have_wd    = have_dec;
      if (v_r == store_rd) begin
        hv_nxt = have_dec;
      end
      if (evict_dec) begin
        match_nxt = match_r - CMP_W'(1);
      end
    end

    if (cmd.commit) begin
      unique case (act_r)
        swmm_pkg::ACT_CLEAR: begin
          wp_nxt     = '0;
          fl_nxt     = '0;
          match_nxt  = '0;
          hits_nxt   = '0;
          o_full_nxt = 1'b0;
          o_ok_nxt   = 1'b0;
        end
        swmm_pkg::ACT_REQUIRE: begin
          need_we    = !need_sat;
          match_nxt  = match_r + CMP_W'(req_hit);
          o_full_nxt = full;
          o_ok_nxt   = 1'b0;
        end
        swmm_pkg::ACT_PUSH: begin
          have_we    = 1'b1;
          store_we   = 1'b1;
          wp_nxt     = wp_inc;
          fl_nxt     = fl_push;
          match_nxt  = match_add;
          hits_nxt   = hits_r + HITS_W'(ok_push);
          o_full_nxt = full_push;
          o_ok_nxt   = ok_push;
        end
        default: begin
          o_full_nxt = full;
          o_ok_nxt   = 1'b0;
        end
      endcase
      o_matched_nxt = match_nxt[MO_W-1:0];
      o_hits_nxt    = hits_nxt;
    end

    if (cmd.sweep_step) begin
      have_we       = 1'b1;
      have_waddr    = sweep_cnt_r;
      have_wd       = '0;
      need_we       = cmd.sweep_need;
      need_waddr    = sweep_cnt_r;
      need_wd       = '0;
      sweep_cnt_nxt = sweep_cnt_r + VALUE_BITS'(1);
    end
    if (cmd.sweep_clr) begin
      sweep_cnt_nxt = '0;
    end

    if (cfg_we) begin
      unique case (swmm_pkg::cfg_idx_t'(cfg_index))
        swmm_pkg::CFG_WINDOW_LEN: begin
          cfg_len_nxt = cfg_wdata;
          wp_nxt      = '0;
          fl_nxt      = '0;
          match_nxt   = '0;
        end
        swmm_pkg::CFG_THRESHOLD: begin
          cfg_thr_nxt = cfg_wdata;
        end
        default: begin
          cfg_thr_nxt = cfg_thr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_len_r   <= swmm_pkg::CFG_LEN_RST;
      cfg_thr_r   <= swmm_pkg::CFG_THR_RST;
      wp_r        <= '0;
      fl_r        <= '0;
      match_r     <= '0;
      hits_r      <= '0;
      sweep_cnt_r <= '0;
    end else begin
      cfg_len_r   <= cfg_len_nxt;
      cfg_thr_r   <= cfg_thr_nxt;
      wp_r        <= wp_nxt;
      fl_r        <= fl_nxt;
      match_r     <= match_nxt;
      hits_r      <= hits_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    v_r       <= v_nxt;
    hv_r      <= hv_nxt;
    nv_r      <= nv_nxt;
    o_full    <= o_full_nxt;
    o_ok      <= o_ok_nxt;
    o_matched <= o_matched_nxt;
    o_hits    <= o_hits_nxt;
  end

  swmm_ram #(
    .WIDTH (HAVE_W),
    .DEPTH (NVALUES)
  ) u_have_ram (
    .clk   (clk),
    .we    (have_we),
    .waddr (have_waddr),
    .wdata (have_wd),
    .raddr (cnt_raddr),
    .rdata (have_rd)
  );

  swmm_ram #(
    .WIDTH (NEED_W),
    .DEPTH (NVALUES)
  ) u_need_ram (
    .clk   (clk),
    .we    (need_we),
    .waddr (need_waddr),
    .wdata (need_wd),
    .raddr (cnt_raddr),
    .rdata (need_rd)
  );

  swmm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_window_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (wp_r),
    .wdata (v_r),
    .raddr (store_raddr),
    .rdata (store_rd)
  );

endmodule
